// ===== sv/lrip_pkg.sv =====
`timescale 1ns / 1ps
// Package for the lidar range image projection unit: field widths, codes, state type
// and the CORDIC arctangent table. No dependencies.

package lrip_pkg;

    // image geometry defaults
    localparam int LRIP_ROWS    = 16;
    localparam int LRIP_COLUMNS = 1800;

    // stream and field widths
    localparam int COORD_W     = 20;
    localparam int RING_W      = 8;
    localparam int ROW_W       = 7;
    localparam int COL_OUT_W   = 12;
    localparam int CELL_OUT_W  = 16;
    localparam int RANGE_W     = 20;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 56;

    // configuration port
    localparam int CFG_W     = 20;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_STEP = 2'd2;
    localparam logic [CFG_W-1:0]  MIN_RANGE_RST = 20'd1000;
    localparam logic [CFG_W-1:0]  MAX_RANGE_RST = 20'd100000;
    localparam logic [STEP_W-1:0] RING_STEP_RST = 5'd1;

    // operation codes
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // arithmetic
    localparam int MUL_W        = 21;
    localparam int SQ_W         = 40;
    localparam int SQRT_STEPS   = 20;
    localparam int CORDIC_STEPS = 22;
    localparam int CORDIC_W     = 42;
    localparam int CORDIC_SCALE = 20;
    localparam int ANG_W        = 26;
    localparam int THETA_W      = 18;
    localparam int ANG_DROP     = 8;
    localparam int ANG_ROUND    = 128;
    localparam int QUARTER_TURN = 16384;
    localparam int COL_DROP     = 16;
    localparam int COL_ROUND    = 32768;
    localparam int MOD_STEPS    = 8;
    localparam int CNT_W        = 5;
    localparam int SQ_CYCLES    = 5;
    localparam logic signed [ANG_W-1:0] HALF_TURN = 26'sd8388608;

    // occupancy memory word
    localparam int OCC_W   = 32;
    localparam int OCC_WSH = 5;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK,
        STS_RANGE,
        STS_BAD_RING,
        STS_SKIP,
        STS_BAD_COL,
        STS_TAKEN,
        STS_CLEARED
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SQ,
        S_ITER,
        S_THETA,
        S_QMUL,
        S_RQ,
        S_COL,
        S_CELL,
        S_RD,
        S_WR,
        S_OUT
    } t_state;

    // atan(2^-i) in units of 2^-24 turn
    function automatic logic signed [ANG_W-1:0] atan_step(input logic [CNT_W-1:0] idx);
        logic signed [ANG_W-1:0] a;
        case (idx)
            5'd0:    a = 26'sd2097152;
            5'd1:    a = 26'sd1238021;
            5'd2:    a = 26'sd654136;
            5'd3:    a = 26'sd332050;
            5'd4:    a = 26'sd166669;
            5'd5:    a = 26'sd83416;
            5'd6:    a = 26'sd41718;
            5'd7:    a = 26'sd20860;
            5'd8:    a = 26'sd10430;
            5'd9:    a = 26'sd5215;
            5'd10:   a = 26'sd2608;
            5'd11:   a = 26'sd1304;
            5'd12:   a = 26'sd652;
            5'd13:   a = 26'sd326;
            5'd14:   a = 26'sd163;
            5'd15:   a = 26'sd81;
            5'd16:   a = 26'sd41;
            5'd17:   a = 26'sd20;
            5'd18:   a = 26'sd10;
            5'd19:   a = 26'sd5;
            5'd20:   a = 26'sd3;
            5'd21:   a = 26'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/lidar_range_image_projection_unit.sv =====
`timescale 1ns / 1ps
// Lidar range image projection unit: range gating, ring downsampling, azimuth column
// and first-point-per-cell occupancy. Depends on lrip_pkg.

// One beat in, one beat out. A point is accepted, then uses the shared 21x21 multiplier
// for the squares and the range limit, then makes 22 passes of the iteration loop that
// runs the CORDIC vectoring step, the square-root step and the ring-step remainder side
// by side, then does column rounding, cell index and the occupancy read-modify-write; a
// point rejected on range or ring skips the column and occupancy steps. The input is not
// ready while a point is in flight, so a new point enters only after the result is taken.
// After reset and on every frame-start beat the occupancy memory is swept one 32-bit word
// per cycle over all ceil(ROWS*COLUMNS/32) words (900 at 16 x 1800); the frame-start
// result comes out when the sweep is done.
// Configuration writes are taken at any time and should land while the unit is idle.

module lidar_range_image_projection_unit
    import lrip_pkg::*;
#(
    parameter int ROWS    = LRIP_ROWS,
    parameter int COLUMNS = LRIP_COLUMNS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // point_x[19:0], point_y[39:20], point_z[59:40], ring_number[67:60], zero[71:68]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation[0]
    input  logic [0:0]             s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // row_index[6:0], column_index[18:7], cell_index[34:19], range_mm[54:35],
    // density_row[55]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [STATUS_W-1:0]    m_axis_tuser
);

    localparam int CELLS      = ROWS * COLUMNS;
    localparam int CELL_W     = $clog2(CELLS);
    localparam int OCC_DEPTH  = (CELLS + OCC_W - 1) / OCC_W;
    localparam int ADDR_W     = (OCC_DEPTH > 1) ? $clog2(OCC_DEPTH) : 1;
    localparam int COL_IDX_W  = $clog2(COLUMNS);
    localparam int COL_W      = COL_IDX_W + 3;
    localparam int MAG_W      = COL_IDX_W + 2;
    localparam int Q_W        = THETA_W + COL_IDX_W + 2;
    localparam int HALF_COLS  = COLUMNS / 2;
    localparam int DENS_ROW_A = ROWS / 2 + 2;
    localparam int DENS_ROW_B = ROWS / 2 + 4;

    localparam logic signed [COL_W-1:0] COL_HALF_S = COL_W'(HALF_COLS);
    localparam logic signed [COL_W-1:0] COLS_S     = COL_W'(COLUMNS);

    // control state
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic                 r_clr_frame;
    logic [CFG_W-1:0]     r_min;
    logic [CFG_W-1:0]     r_max;
    logic [STEP_W-1:0]    r_step;

    // payload
    logic signed [COORD_W-1:0]   r_x, r_y, r_z;
    logic [RING_W-1:0]           r_ring;
    logic [ROW_W-1:0]            r_row;
    logic                        r_zero_xy;
    logic signed [2*MUL_W-1:0]   r_prod;
    logic [SQ_W-1:0]             r_sq;
    logic                        r_range_hi;
    logic [SQ_W-1:0]             r_root;
    logic [SQ_W-1:0]             r_bit;
    logic signed [CORDIC_W-1:0]  r_u, r_v;
    logic signed [ANG_W-1:0]     r_ang;
    logic [STEP_W-1:0]           r_rem;
    logic signed [THETA_W-1:0]   r_theta;
    logic [MAG_W-1:0]            r_mag;
    logic                        r_qneg;
    logic [COL_IDX_W-1:0]        r_col;
    logic [CELL_W-1:0]           r_cell;
    t_status                     r_status;

    // occupancy memory
    logic [OCC_W-1:0]  r_occ_mem [OCC_DEPTH];
    logic [OCC_W-1:0]  r_rdata;
    logic              occ_we;
    logic [ADDR_W-1:0] occ_waddr;
    logic [ADDR_W-1:0] occ_raddr;
    logic [OCC_W-1:0]  occ_wdata;
    logic              occ_hit;

    // input fields
    logic                       in_accept;
    logic signed [COORD_W-1:0]  in_x, in_y, in_z;
    logic [RING_W-1:0]          in_ring;
    logic signed [CORDIC_W-1:0] in_u, in_v;

    // shared multiplier
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [THETA_W:0]    theta_off;

    // iteration loop
    logic [SQ_W:0]              sq_trial;
    logic                       sq_ge;
    logic signed [CORDIC_W-1:0] du, dv;
    logic signed [ANG_W-1:0]    ang_inc;
    logic [STEP_W-1:0]          step_eff;
    logic [STEP_W:0]            mod_trial;
    logic                       mod_ge;
    logic [STEP_W-1:0]          rem_next;

    // post processing
    logic [ANG_W-1:0]           ang_abs;
    logic [ANG_W-1:0]           ang_rnd;
    logic [THETA_W-2:0]         theta_mag;
    logic signed [THETA_W-1:0]  theta_new;
    logic                       range_out, ring_bad, ring_skip, reject;
    logic signed [Q_W-1:0]      q;
    logic [Q_W-1:0]             q_abs;
    logic [Q_W:0]               q_rnd;
    logic signed [COL_W-1:0]    mag_s, col_raw, col_wrap;
    logic                       col_bad;
    logic                       clr_last;

    // output shaping
    logic                       has_cell, is_point, dens;
    logic [31:0]                cell_ext;
    logic [COL_OUT_W-1:0]       out_col;
    logic [CELL_OUT_W-1:0]      out_cell;
    logic [RANGE_W-1:0]         out_range;
    logic [ROW_W-1:0]           out_row;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_x      = signed'(s_axis_tdata[COORD_W-1:0]);
    assign in_y      = signed'(s_axis_tdata[2*COORD_W-1:COORD_W]);
    assign in_z      = signed'(s_axis_tdata[3*COORD_W-1:2*COORD_W]);
    assign in_ring   = s_axis_tdata[3*COORD_W+RING_W-1:3*COORD_W];
    assign in_u      = CORDIC_W'(in_y) <<< CORDIC_SCALE;
    assign in_v      = CORDIC_W'(in_x) <<< CORDIC_SCALE;

    assign clr_last  = (r_clr_addr == ADDR_W'(OCC_DEPTH - 1));

    // ---------------- shared multiplier operand select ----------------
    assign theta_off = (THETA_W+1)'(r_theta) - (THETA_W+1)'(QUARTER_TURN);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                case (r_cnt)
                    5'd0: begin
                        mul_a = MUL_W'(r_x);
                        mul_b = MUL_W'(r_x);
                    end
                    5'd1: begin
                        mul_a = MUL_W'(r_y);
                        mul_b = MUL_W'(r_y);
                    end
                    5'd2: begin
                        mul_a = MUL_W'(r_z);
                        mul_b = MUL_W'(r_z);
                    end
                    default: begin
                        mul_a = signed'(MUL_W'(r_max));
                        mul_b = signed'(MUL_W'(r_max));
                    end
                endcase
            end
            S_QMUL: begin
                mul_a = MUL_W'(theta_off);
                mul_b = MUL_W'(COLUMNS);
            end
            S_RQ: begin
                mul_a = signed'(MUL_W'(r_row));
                mul_b = MUL_W'(COLUMNS);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- iteration loop steps ----------------
    assign sq_trial  = {1'b0, r_root} + {1'b0, r_bit};
    assign sq_ge     = {1'b0, r_sq} >= sq_trial;

    assign du        = r_v >>> r_cnt;
    assign dv        = r_u >>> r_cnt;
    assign ang_inc   = atan_step(r_cnt);

    // ring remainder, restoring, one ring bit per step from the top
    assign step_eff  = (r_step == '0) ? STEP_W'(1) : r_step;
    assign mod_trial = {r_rem, r_ring[3'd7 - r_cnt[2:0]]};
    assign mod_ge    = mod_trial >= {1'b0, step_eff};
    assign rem_next  = mod_ge ? STEP_W'(mod_trial - {1'b0, step_eff}) : mod_trial[STEP_W-1:0];

    // ---------------- angle rounding and gating ----------------
    assign ang_abs   = (r_ang < 0) ? ANG_W'(-r_ang) : ANG_W'(r_ang);
    assign ang_rnd   = ang_abs + ANG_W'(ANG_ROUND);
    assign theta_mag = ang_rnd[ANG_DROP +: THETA_W-1];

    always_comb begin
        if (r_zero_xy) begin
            theta_new = '0;
        end else if (r_ang < 0) begin
            theta_new = -signed'({1'b0, theta_mag});
        end else begin
            theta_new = signed'({1'b0, theta_mag});
        end
    end

    assign range_out = (r_root[RANGE_W-1:0] < r_min) || r_range_hi;
    assign ring_bad  = {1'b0, r_ring} >= (RING_W+1)'(ROWS);
    assign ring_skip = (r_rem != '0);
    assign reject    = range_out || ring_bad || ring_skip;

    // ---------------- column ----------------
    assign q      = signed'(r_prod[Q_W-1:0]);
    assign q_abs  = q[Q_W-1] ? Q_W'(-q) : Q_W'(q);
    assign q_rnd  = {1'b0, q_abs} + (Q_W+1)'(COL_ROUND);

    assign mag_s  = signed'(COL_W'(r_mag));

    always_comb begin
        col_raw  = r_qneg ? (COL_HALF_S + mag_s) : (COL_HALF_S - mag_s);
        col_wrap = (col_raw >= COLS_S) ? (col_raw - COLS_S) : col_raw;
        col_bad  = (col_wrap < 0) || (col_wrap >= COLS_S);
    end

    // ---------------- occupancy memory ----------------
    assign occ_raddr = ADDR_W'(r_cell >> OCC_WSH);
    assign occ_hit   = r_rdata[r_cell[OCC_WSH-1:0]];

    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            r_occ_mem[occ_waddr] <= occ_wdata;
        end
        r_rdata <= r_occ_mem[occ_raddr];
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = r_clr_frame ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (s_axis_tuser[0] == OP_FRAME) ? S_CLEAR : S_SQ;
                end
            end
            S_SQ: begin
                if (r_cnt == CNT_W'(SQ_CYCLES - 1)) begin
                    n_state = S_ITER;
                end
            end
            S_ITER: begin
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_THETA;
                end
            end
            S_THETA: n_state = reject ? S_OUT : S_QMUL;
            S_QMUL:  n_state = S_RQ;
            S_RQ:    n_state = S_COL;
            S_COL:   n_state = col_bad ? S_OUT : S_CELL;
            S_CELL:  n_state = S_RD;
            S_RD:    n_state = S_WR;
            S_WR:    n_state = S_OUT;
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        occ_we        = 1'b0;
        occ_waddr     = occ_raddr;
        occ_wdata     = r_rdata | (OCC_W'(1) << r_cell[OCC_WSH-1:0]);
        case (r_state)
            S_CLEAR: begin
                occ_we    = 1'b1;
                occ_waddr = r_clr_addr;
                occ_wdata = '0;
            end
            S_IDLE:  s_axis_tready = 1'b1;
            S_WR:    occ_we = !occ_hit;
            S_OUT:   m_axis_tvalid = 1'b1;
            default: begin
                s_axis_tready = 1'b0;
                m_axis_tvalid = 1'b0;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_clr_addr  <= '0;
            r_clr_frame <= 1'b0;
            r_min       <= MIN_RANGE_RST;
            r_max       <= MAX_RANGE_RST;
            r_step      <= RING_STEP_RST;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_RANGE: r_min  <= i_cfg_data;
                    CFG_MAX_RANGE: r_max  <= i_cfg_data;
                    CFG_RING_STEP: r_step <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_CLEAR: r_clr_addr <= clr_last ? '0 : r_clr_addr + 1'b1;
                S_IDLE: begin
                    if (in_accept) begin
                        r_clr_frame <= (s_axis_tuser[0] == OP_FRAME);
                        r_cnt       <= '0;
                    end
                end
                S_SQ: begin
                    r_cnt <= (r_cnt == CNT_W'(SQ_CYCLES - 1)) ? '0 : r_cnt + 1'b1;
                end
                S_ITER: begin
                    r_cnt <= (r_cnt == CNT_W'(CORDIC_STEPS - 1)) ? '0 : r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_x       <= in_x;
                    r_y       <= in_y;
                    r_z       <= in_z;
                    r_ring    <= in_ring;
                    r_row     <= ({1'b0, in_ring} < (RING_W+1)'(ROWS)) ? in_ring[ROW_W-1:0] : '0;
                    r_zero_xy <= (in_x == '0) && (in_y == '0);
                    r_rem     <= '0;
                    // fold into the half plane with a non-negative reference axis
                    if (in_y < 0) begin
                        r_u   <= -in_u;
                        r_v   <= -in_v;
                        r_ang <= (in_x >= 0) ? HALF_TURN : -HALF_TURN;
                    end else begin
                        r_u   <= in_u;
                        r_v   <= in_v;
                        r_ang <= '0;
                    end
                    if (s_axis_tuser[0] == OP_FRAME) begin
                        r_status <= STS_CLEARED;
                    end
                end
            end
            S_SQ: begin
                r_prod <= mul_a * mul_b;
                case (r_cnt)
                    5'd0: ;
                    5'd1: r_sq <= r_prod[SQ_W-1:0];
                    5'd2: r_sq <= r_sq + r_prod[SQ_W-1:0];
                    5'd3: r_sq <= r_sq + r_prod[SQ_W-1:0];
                    default: begin
                        // product now holds max_range squared
                        r_range_hi <= {1'b0, r_sq} > r_prod[SQ_W:0];
                        r_root     <= '0;
                        r_bit      <= SQ_W'(1) << (2 * (SQRT_STEPS - 1));
                    end
                endcase
            end
            S_ITER: begin
                if (r_v >= 0) begin
                    r_u   <= r_u + du;
                    r_v   <= r_v - dv;
                    r_ang <= r_ang + ang_inc;
                end else begin
                    r_u   <= r_u - du;
                    r_v   <= r_v + dv;
                    r_ang <= r_ang - ang_inc;
                end
                if (r_cnt < CNT_W'(SQRT_STEPS)) begin
                    if (sq_ge) begin
                        r_sq   <= r_sq - sq_trial[SQ_W-1:0];
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                if (r_cnt < CNT_W'(MOD_STEPS)) begin
                    r_rem <= rem_next;
                end
            end
            S_THETA: begin
                r_theta <= theta_new;
                if (range_out) begin
                    r_status <= STS_RANGE;
                end else if (ring_bad) begin
                    r_status <= STS_BAD_RING;
                end else if (ring_skip) begin
                    r_status <= STS_SKIP;
                end
            end
            S_QMUL: r_prod <= mul_a * mul_b;
            S_RQ: begin
                r_mag  <= q_rnd[COL_DROP +: MAG_W];
                r_qneg <= q[Q_W-1];
                r_prod <= mul_a * mul_b;    // row * COLUMNS for the cell index
            end
            S_COL: begin
                r_col <= col_wrap[COL_IDX_W-1:0];
                if (col_bad) begin
                    r_status <= STS_BAD_COL;
                end
            end
            S_CELL: r_cell <= CELL_W'(r_col) + r_prod[CELL_W-1:0];
            S_WR:   r_status <= occ_hit ? STS_TAKEN : STS_OK;
            default: ;
        endcase
    end

    // ---------------- result beat ----------------
    assign has_cell  = (r_status == STS_OK) || (r_status == STS_TAKEN);
    assign is_point  = (r_status != STS_CLEARED);
    assign cell_ext  = 32'(r_cell);
    assign out_col   = has_cell ? COL_OUT_W'(r_col) : '0;
    assign out_cell  = has_cell ? cell_ext[CELL_OUT_W-1:0] : '0;
    assign out_range = is_point ? r_root[RANGE_W-1:0] : '0;
    assign out_row   = is_point ? r_row : '0;
    assign dens      = (r_status == STS_OK) &&
                       ((r_row == ROW_W'(DENS_ROW_A)) || (r_row == ROW_W'(DENS_ROW_B)));

    assign m_axis_tdata = {dens, out_range, out_cell, out_col, out_row};
    assign m_axis_tuser = r_status;

endmodule
